@@ hw/rtl/plt_pkg.sv @@
// Shared types, constants and helpers for the piecewise linear lookup unit.
`timescale 1ns / 1ps

package plt_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
  localparam int X_W        = 16;
  localparam int Y_W        = 16;
  localparam int PROD_W     = 2 * X_W;
  localparam int DIV_STEPS  = X_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] POINT_COUNT_RST = COUNT_W'(2);

  // Item kinds carried on in_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Register indexes
  localparam logic REG_POINT_COUNT = 1'b0;

  typedef struct packed {
    logic [X_W-1:0]        x;
    logic signed [Y_W-1:0] y;
  } bp_entry_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [X_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [X_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_LAST,
    ST_CHK_FIRST,
    ST_SEARCH,
    ST_PREP,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } plt_state_t;

  // Clamp the programmed count to 2..MAX_POINTS and return the top index.
  function automatic logic [IDX_W-1:0] last_index(input logic [COUNT_W-1:0] count);
    logic [COUNT_W-1:0] n;
    n = count;
    if (n < COUNT_W'(2)) begin
      n = COUNT_W'(2);
    end
    if (n > COUNT_W'(MAX_POINTS)) begin
      n = COUNT_W'(MAX_POINTS);
    end
    return IDX_W'(n - COUNT_W'(1));
  endfunction

endpackage

@@ hw/rtl/plt_table.sv @@
// Breakpoint table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module plt_table (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [plt_pkg::IDX_W-1:0] wr_addr,
  input  plt_pkg::bp_entry_t      wr_data,
  input  logic [plt_pkg::IDX_W-1:0] rd_addr,
  output plt_pkg::bp_entry_t      rd_data
);
  import plt_pkg::*;

  bp_entry_t mem [MAX_POINTS];
  bp_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/plt_div.sv @@
// Restoring divider, one quotient bit per cycle through a shared subtractor.
`timescale 1ns / 1ps

module plt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  plt_pkg::div_req_t req,
  output plt_pkg::div_rsp_t rsp
);
  import plt_pkg::*;

  logic [X_W-1:0]       rem_r;
  logic [X_W-1:0]       quo_r;
  logic [X_W-1:0]       divisor_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [X_W:0]   trial;
  logic           ge;
  logic [X_W:0]   diff;

  // Dividend high half is below the divisor, so the quotient fits in X_W bits.
  assign trial = {rem_r, quo_r[X_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign ge    = (trial >= {1'b0, divisor_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= req.dividend[PROD_W-1:X_W];
      quo_r     <= req.dividend[X_W-1:0];
      divisor_r <= req.divisor;
      cnt_r     <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy_r) begin
      rem_r <= ge ? diff[X_W-1:0] : trial[X_W-1:0];
      quo_r <= {quo_r[X_W-2:0], ge};
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0 && !req.start) |=> (done_r && !busy_r))
    else $error("divider did not finish after last step");

endmodule

@@ hw/rtl/piecewise_linear_table_lookup_unit.sv @@
// Top level of the piecewise linear table lookup unit.
`timescale 1ns / 1ps

// Piecewise linear lookup over a table of up to 16 breakpoints (ascending
// unsigned 16-bit x, signed 16-bit y). An input transfer with tuser = 0 writes
// one breakpoint and returns nothing; tuser = 1 converts lookup_value to a y
// and returns one result transfer. Inputs at or above the last x or at or
// below the first x return that end's y; anything between is interpolated
// toward the next breakpoint, with the step |dy|*dx/span truncated. The
// block handles one item at a time. A lookup clamped at the upper end reads
// only the last entry, one clamped at the lower end also reads entry 0, and
// an interpolated lookup also walks the table downward in a search and then
// divides. The length of an interpolated lookup is set by the single read
// port of the table, read once a cycle during the search, and by the
// 16-step restoring divider. A finished result sits in the output
// register while the next item is accepted. The point_count register (byte
// address 0, clamped to 2..16 in use) may only be written while the block is
// idle; every entry that a lookup reaches must have been written first.

module piecewise_linear_table_lookup_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: entry_index[3:0], point_x[19:4], point_y[35:20],
  // lookup_value[51:36], zero fill[55:52]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [plt_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: opcode[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: result_value[15:0]
  output logic [plt_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [plt_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [plt_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [plt_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import plt_pkg::*;

  // Unpack the input transfer
  logic [IDX_W-1:0] in_entry_index;
  bp_entry_t        in_point;
  logic [X_W-1:0]   in_lookup_value;

  assign in_entry_index  = in_tdata[3:0];
  assign in_point.x      = in_tdata[19:4];
  assign in_point.y      = in_tdata[35:20];
  assign in_lookup_value = in_tdata[51:36];

  // Configuration register
  logic [COUNT_W-1:0] point_count_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= POINT_COUNT_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_POINT_COUNT) begin
      point_count_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_POINT_COUNT) begin
      cfg_prdata = CFG_DATA_W'(point_count_r);
    end
  end

  logic [IDX_W-1:0] last_idx;
  assign last_idx = last_index(point_count_r);

  // Sequencer and datapath registers
  plt_state_t            state_r, state_nxt;
  logic [X_W-1:0]        val_r;
  bp_entry_t             hi_r;
  bp_entry_t             lo_r;
  logic [IDX_W-1:0]      idx_r;
  logic [X_W-1:0]        din_r;
  logic [X_W-1:0]        dbp_r;
  logic [X_W-1:0]        mag_r;
  logic                  neg_r;
  logic [PROD_W-1:0]     prod_r;
  logic signed [Y_W-1:0] res_r;
  logic                  out_valid_r;
  logic [Y_W-1:0]        out_data_r;

  logic             in_xfer;
  logic             out_free;
  logic             tbl_wr;
  logic [IDX_W-1:0] rd_addr;
  bp_entry_t        rd_entry;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             search_more;
  logic [Y_W:0]     dy;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign tbl_wr   = in_xfer && in_tuser == OP_WRITE;

  // Keep walking down while above entry 0 and the input is not above this x
  assign search_more = (idx_r != '0) && (val_r <= rd_entry.x);

  plt_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (in_entry_index),
    .wr_data (in_point),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  plt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_tuser == OP_LOOKUP) begin
          state_nxt = ST_CHK_LAST;
        end
      end
      ST_CHK_LAST: begin
        state_nxt = (val_r >= rd_entry.x) ? ST_DONE : ST_CHK_FIRST;
      end
      ST_CHK_FIRST: begin
        state_nxt = (val_r <= rd_entry.x) ? ST_DONE : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!search_more) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP:     state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, table read address, divider start
  always_comb begin
    in_tready = 1'b0;
    rd_addr   = last_idx;
    div_req   = '{start: 1'b0, dividend: prod_r, divisor: dbp_r};
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        rd_addr   = last_idx;
      end
      ST_CHK_LAST:  rd_addr = '0;
      ST_CHK_FIRST: rd_addr = last_idx - IDX_W'(1);
      ST_SEARCH:    rd_addr = idx_r - IDX_W'(1);
      ST_DIV_GO:    div_req.start = 1'b1;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign dy = {hi_r.y[Y_W-1], hi_r.y} - {lo_r.y[Y_W-1], lo_r.y};

  // Datapath: hold the operand entries, form dx, span, |dy| and product, then the result
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        val_r <= in_lookup_value;
      end
      ST_CHK_LAST: begin
        hi_r  <= rd_entry;
        res_r <= rd_entry.y;
      end
      ST_CHK_FIRST: begin
        res_r <= rd_entry.y;
        idx_r <= last_idx - IDX_W'(1);
      end
      ST_SEARCH: begin
        if (search_more) begin
          hi_r  <= rd_entry;
          idx_r <= idx_r - IDX_W'(1);
        end else begin
          lo_r <= rd_entry;
        end
      end
      ST_PREP: begin
        din_r <= val_r - lo_r.x;
        dbp_r <= hi_r.x - lo_r.x;
        neg_r <= dy[Y_W];
        mag_r <= dy[Y_W] ? Y_W'(-dy) : dy[Y_W-1:0];
      end
      ST_MUL: begin
        prod_r <= mag_r * din_r;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          res_r <= neg_r ? lo_r.y - $signed(div_rsp.quotient)
                         : lo_r.y + $signed(div_rsp.quotient);
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  // Output register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV_GO |-> dbp_r != '0)
    else $error("interpolation span is zero");

  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV_GO |-> prod_r[PROD_W-1:X_W] < dbp_r)
    else $error("quotient would overflow the divider");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result loaded outside the finish state");

  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV_WAIT |-> (div_rsp.busy || div_rsp.done))
    else $error("divider idle while a quotient is awaited");

endmodule
